// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the block.
// Define SYNTH to compile them away for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that cons holds in the same cycle whenever ante holds.
`define BCQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define BCQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BCQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BCQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/core/bcq_pkg.sv =====
// Shared types and constants of the blocked character queue.
// No dependencies.
`timescale 1ns / 1ps

package bcq_pkg;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;

    typedef logic [ACTION_W-1:0] action_t;

    // Action codes carried on s_tuser
    localparam action_t ACT_PUT   = 2'd0;
    localparam action_t ACT_UNPUT = 2'd1;
    localparam action_t ACT_GET   = 2'd2;
    localparam action_t ACT_FLUSH = 2'd3;

    // Byte store operation decided by the ring control for one transaction
    typedef struct packed {
        logic wr_en;     // write data byte at the store address
        logic rd_en;     // read the store address (get that hits)
        logic put_fail;  // tail block full and no block free
    } bcq_op_t;

endpackage

// ===== rtl/core/bcq_ring_ctrl.sv =====
// Block ring bookkeeping of the blocked character queue: head slot, block
// count, head read index, tail write index and unread count. Uses bcq_pkg.
`timescale 1ns / 1ps

module bcq_ring_ctrl #(
    parameter int BLOCK_BYTES = 64,
    parameter int MAX_BLOCKS  = 16,
    localparam int DEPTH = BLOCK_BYTES * MAX_BLOCKS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  bcq_pkg::action_t action,
    output bcq_pkg::bcq_op_t op,
    output logic [AW-1:0]    mem_addr,
    output logic [CW-1:0]    free_next
);
    import bcq_pkg::*;

    localparam int XW = $clog2(BLOCK_BYTES + 1);
    localparam int SW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int BW = $clog2(MAX_BLOCKS + 1);

    // Blocks between head and tail are always full and unread, so only the
    // head read index and the tail write index need to be kept.
    logic [SW-1:0] head_reg, head_next;
    logic [BW-1:0] used_reg, used_next;
    logic [XW-1:0] rd_idx_reg, rd_idx_next;
    logic [XW-1:0] wr_idx_reg, wr_idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [SW:0]   tail_sum;
    logic [SW:0]   open_sum;
    logic [SW-1:0] tail_slot;
    logic [SW-1:0] open_slot;
    logic [SW-1:0] head_inc;
    logic [XW-1:0] tail_rd_idx;
    logic [XW-1:0] head_wr_idx;
    logic [SW-1:0] slot_sel;
    logic [XW-1:0] idx_sel;

    // Ring slot arithmetic, each sum stays below twice the ring size
    always_comb begin
        tail_sum  = {1'b0, head_reg} + (SW+1)'(used_reg - BW'(1));
        open_sum  = {1'b0, head_reg} + (SW+1)'(used_reg);
        tail_slot = (tail_sum >= (SW+1)'(MAX_BLOCKS)) ?
                    SW'(tail_sum - (SW+1)'(MAX_BLOCKS)) : SW'(tail_sum);
        open_slot = (open_sum >= (SW+1)'(MAX_BLOCKS)) ?
                    SW'(open_sum - (SW+1)'(MAX_BLOCKS)) : SW'(open_sum);
        head_inc  = (head_reg == SW'(MAX_BLOCKS - 1)) ? '0 : head_reg + SW'(1);
        // A lone block is both head and tail
        tail_rd_idx = (used_reg == BW'(1)) ? rd_idx_reg : '0;
        head_wr_idx = (used_reg == BW'(1)) ? wr_idx_reg : XW'(BLOCK_BYTES);
    end

    // Decide the step for one transaction
    always_comb begin
        head_next   = head_reg;
        used_next   = used_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        cnt_next    = cnt_reg;
        op          = '0;
        slot_sel    = head_reg;
        idx_sel     = rd_idx_reg;
        case (action)
            ACT_PUT: begin
                if (used_reg == '0) begin
                    // open the first block at the head slot
                    op.wr_en    = 1'b1;
                    slot_sel    = head_reg;
                    idx_sel     = '0;
                    used_next   = BW'(1);
                    rd_idx_next = '0;
                    wr_idx_next = XW'(1);
                    cnt_next    = cnt_reg + CW'(1);
                end else if (wr_idx_reg == XW'(BLOCK_BYTES)) begin
                    if (used_reg == BW'(MAX_BLOCKS)) begin
                        op.put_fail = 1'b1;
                    end else begin
                        // open the next block behind the tail
                        op.wr_en    = 1'b1;
                        slot_sel    = open_slot;
                        idx_sel     = '0;
                        used_next   = used_reg + BW'(1);
                        wr_idx_next = XW'(1);
                        cnt_next    = cnt_reg + CW'(1);
                    end
                end else begin
                    op.wr_en    = 1'b1;
                    slot_sel    = tail_slot;
                    idx_sel     = wr_idx_reg;
                    wr_idx_next = wr_idx_reg + XW'(1);
                    cnt_next    = cnt_reg + CW'(1);
                end
            end
            ACT_UNPUT: begin
                if (used_reg != '0) begin
                    wr_idx_next = wr_idx_reg - XW'(1);
                    cnt_next    = cnt_reg - CW'(1);
                    // release an emptied tail; the one before it is full
                    if (wr_idx_reg - XW'(1) == tail_rd_idx) begin
                        used_next   = used_reg - BW'(1);
                        wr_idx_next = XW'(BLOCK_BYTES);
                    end
                end
            end
            ACT_GET: begin
                if (used_reg != '0) begin
                    op.rd_en    = 1'b1;
                    slot_sel    = head_reg;
                    idx_sel     = rd_idx_reg;
                    rd_idx_next = rd_idx_reg + XW'(1);
                    cnt_next    = cnt_reg - CW'(1);
                    // release a drained head and move to the next block
                    if (rd_idx_reg + XW'(1) == head_wr_idx) begin
                        head_next   = head_inc;
                        used_next   = used_reg - BW'(1);
                        rd_idx_next = '0;
                    end
                end
            end
            default: begin
                // flush
                head_next = '0;
                used_next = '0;
                cnt_next  = '0;
            end
        endcase
    end

    // Byte address of the selected block and index
    assign mem_addr  = AW'(32'(slot_sel) * BLOCK_BYTES + 32'(idx_sel));
    assign free_next = CW'(DEPTH) - cnt_next;

    // Advance the ring state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            used_reg   <= '0;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            cnt_reg    <= '0;
        end else if (step) begin
            head_reg   <= head_next;
            used_reg   <= used_next;
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/blocked_char_queue.sv =====
// Top level of the blocked character queue: stream ports, byte store and
// result register. Uses bcq_pkg, bcq_ring_ctrl and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Byte queue kept as a ring of MAX_BLOCKS blocks of BLOCK_BYTES bytes each.
// s_tuser selects the action (0 put, 1 unput, 2 get, 3 flush) and s_tdata
// carries the byte to put. Every transaction gives one result: put failure
// flag, the byte taken by a get (0 otherwise or on an empty queue) and the
// free space after the step. The block takes one transaction per clock while
// its result slot is empty or being emptied; results appear in the cycle after
// acceptance, with the single-port byte store's read data registered. The slot
// is freed in the same cycle it is taken, so a stalled result holds off only the
// next input. The byte store is not cleared after reset; it needs no clearing pass.
module blocked_char_queue #(
    parameter int BLOCK_BYTES = 64,
    parameter int MAX_BLOCKS  = 16,
    localparam int DEPTH = BLOCK_BYTES * MAX_BLOCKS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int OW    = ((1 + bcq_pkg::BYTE_W + CW + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [bcq_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  bcq_pkg::action_t           s_tuser,   // [1:0] action
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OW-1:0]              m_tdata    // status, read_byte, free_space
);
    import bcq_pkg::*;

    logic             step;
    bcq_op_t          op;
    logic [AW-1:0]    mem_addr;
    logic [CW-1:0]    free_next;

    logic [BYTE_W-1:0] store_mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              m_valid_reg;
    logic              status_reg;
    logic              hit_reg;
    logic [CW-1:0]     free_reg;
    logic [BYTE_W-1:0] read_byte;

    // Accept while the result slot is empty or being emptied
    assign s_tready = !m_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    bcq_ring_ctrl #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_ring_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .action    (s_tuser),
        .op        (op),
        .mem_addr  (mem_addr),
        .free_next (free_next)
    );

    // Byte store: write on put, registered read on get
    always_ff @(posedge aclk) begin
        if (step && op.wr_en) begin
            store_mem[mem_addr] <= s_tdata;
        end
        if (step && op.rd_en) begin
            rd_data_reg <= store_mem[mem_addr];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            status_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= CW'(DEPTH);
        end else begin
            if (step) begin
                m_valid_reg <= 1'b1;
                status_reg  <= op.put_fail;
                hit_reg     <= op.rd_en;
                free_reg    <= free_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign read_byte = hit_reg ? rd_data_reg : '0;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = OW'({free_reg, read_byte, status_reg});

    // Free space moves by exactly one on a stored or removed byte
    `BCQ_ASSERT_IMP(a_put_free, aclk, aresetn, step && op.wr_en, free_next == free_reg - CW'(1), "put did not take one byte of space")
    `BCQ_ASSERT_IMP(a_get_free, aclk, aresetn, step && op.rd_en, free_next == free_reg + CW'(1), "get did not return one byte of space")
    // A put only fails when every block is taken; only bytes already read
    // from the head block can be free then
    `BCQ_ASSERT_IMP(a_fail_full, aclk, aresetn, step && op.put_fail, free_reg < CW'(BLOCK_BYTES), "put failed with a block of space left")
    // Every accepted transaction shows a result in the next cycle
    `BCQ_ASSERT_NEXT(a_result, aclk, aresetn, step, m_valid_reg, "accepted transaction gave no result")

endmodule
